// ===== sv/bcu_pkg.sv =====
// shared types, constants and controller/datapath command and status for the binomial unit
package bcu_pkg;

   localparam int ResultWidthDefault = 32;
   localparam int InWidth            = 32;
   localparam int TopWidth           = InWidth + 1;
   localparam int ProdWidth          = 64;
   localparam int ProdFullWidth      = ProdWidth + 1;
   localparam int DivSteps           = ProdWidth;
   localparam int DivCntWidth        = $clog2(DivSteps + 1);

   localparam logic OP_CHOOSE      = 1'b0;
   localparam logic OP_MULTICHOOSE = 1'b1;

   typedef struct packed {
      logic               operation;
      logic [InWidth-1:0] n_value;
      logic [InWidth-1:0] k_value;
   } req_type;

   typedef struct packed {
      logic [InWidth-1:0] coefficient;
      logic               overflow;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic setup;
      logic mul;
      logic step;
      logic update;
      logic fin_zero;
      logic fin_ok;
      logic fin_ovf;
   } cmd_type;

   typedef struct packed {
      logic k_gt_top;
      logic loop_done;
      logic div_done;
      logic quo_big;
   } status_type;

endpackage

// ===== sv/bcu_ctrl.sv =====
// controller state machine sequencing the multiply-then-divide steps
module bcu_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   output logic                rsp_strobe,
   output bcu_pkg::cmd_type    cmd,
   input  bcu_pkg::status_type status
);
   import bcu_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SETUP  = 3'd1;
   localparam logic [2:0] S_LOOP   = 3'd2;
   localparam logic [2:0] S_DIV    = 3'd3;
   localparam logic [2:0] S_UPDATE = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       strobe_ff, strobe_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            if (status.k_gt_top) begin
               cmd.fin_zero = 1'b1;
               state_in     = S_IDLE;
            end else begin
               cmd.setup = 1'b1;
               state_in  = S_LOOP;
            end
         end
         S_LOOP: begin
            if (status.loop_done) begin
               cmd.fin_ok = 1'b1;
               state_in   = S_IDLE;
            end else begin
               cmd.mul  = 1'b1;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (status.div_done) begin
               state_in = S_UPDATE;
            end else begin
               cmd.step = 1'b1;
            end
         end
         S_UPDATE: begin
            // running value only grows, so stopping at the first overflow is exact
            if (status.quo_big) begin
               cmd.fin_ovf = 1'b1;
               state_in    = S_IDLE;
            end else begin
               cmd.update = 1'b1;
               state_in   = S_LOOP;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign strobe_in = cmd.fin_zero | cmd.fin_ok | cmd.fin_ovf;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;

endmodule

// ===== sv/bcu_dpath.sv =====
// datapath: operand registers, multiplier, restoring divider and result register
module bcu_dpath #(
   parameter int RESULT_WIDTH = bcu_pkg::ResultWidthDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  bcu_pkg::req_type     req_data,
   input  bcu_pkg::cmd_type     cmd,
   output bcu_pkg::status_type  status,
   output bcu_pkg::rsp_type     rsp_data
);
   import bcu_pkg::*;

   localparam logic [RESULT_WIDTH-1:0] Limit = {RESULT_WIDTH{1'b1}};

   logic [TopWidth-1:0]     top_ff;
   logic [InWidth-1:0]      k_ff;
   logic [InWidth-1:0]      a_ff;
   logic [InWidth-1:0]      i_ff;
   logic [RESULT_WIDTH-1:0] c_ff;
   logic [InWidth:0]        rem_ff, rem_in;
   logic [ProdWidth-1:0]    quo_ff, quo_in;
   logic [DivCntWidth-1:0]  cnt_ff;
   rsp_type                 rsp_ff;

   logic [TopWidth-1:0]      top_in;
   logic [TopWidth-1:0]      diff;
   logic [InWidth-1:0]       a_in;
   logic [TopWidth-1:0]      tmi;
   logic [TopWidth-1:0]      divisor;
   logic [ProdFullWidth-1:0] prod_full;
   logic [InWidth+1:0]       shifted;
   logic [InWidth+1:0]       trial;

   // multichoose maps onto choose(n + k - 1, k) at 33 bits
   always_comb begin
      if (req_data.operation == OP_MULTICHOOSE) begin
         top_in = {1'b0, req_data.n_value} + {1'b0, req_data.k_value} - TopWidth'(1);
      end else begin
         top_in = {1'b0, req_data.n_value};
      end
   end

   assign diff = top_ff - {1'b0, k_ff};
   assign a_in = ({1'b0, k_ff} < diff) ? k_ff : diff[InWidth-1:0];

   assign tmi       = top_ff - {1'b0, i_ff};
   assign divisor   = {1'b0, i_ff} + TopWidth'(1);
   assign prod_full = {{(ProdFullWidth-RESULT_WIDTH){1'b0}}, c_ff}
                    * {{(ProdFullWidth-TopWidth){1'b0}}, tmi};

   // one quotient bit per cycle
   assign shifted = {rem_ff, quo_ff[ProdWidth-1]};
   assign trial   = shifted - {1'b0, divisor};

   always_comb begin
      if (!trial[InWidth+1]) begin
         rem_in = trial[InWidth:0];
         quo_in = {quo_ff[ProdWidth-2:0], 1'b1};
      end else begin
         rem_in = shifted[InWidth:0];
         quo_in = {quo_ff[ProdWidth-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.mul) begin
         cnt_ff <= DivCntWidth'(DivSteps);
      end else if (cmd.step) begin
         cnt_ff <= cnt_ff - DivCntWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         top_ff <= top_in;
         k_ff   <= req_data.k_value;
      end
      if (cmd.setup) begin
         a_ff <= a_in;
         i_ff <= '0;
         c_ff <= RESULT_WIDTH'(1);
      end
      if (cmd.mul) begin
         quo_ff <= prod_full[ProdWidth-1:0];
         rem_ff <= '0;
      end else if (cmd.step) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
      if (cmd.update) begin
         c_ff <= quo_ff[RESULT_WIDTH-1:0];
         i_ff <= i_ff + InWidth'(1);
      end
      if (cmd.fin_zero) begin
         rsp_ff.coefficient <= '0;
         rsp_ff.overflow    <= 1'b0;
      end else if (cmd.fin_ok) begin
         rsp_ff.coefficient <= InWidth'(c_ff);
         rsp_ff.overflow    <= 1'b0;
      end else if (cmd.fin_ovf) begin
         rsp_ff.coefficient <= InWidth'(Limit);
         rsp_ff.overflow    <= 1'b1;
      end
   end

   assign status.k_gt_top  = ({1'b0, k_ff} > top_ff);
   assign status.loop_done = (i_ff == a_ff);
   assign status.div_done  = (cnt_ff == '0);
   assign status.quo_big   = (quo_ff > {{(ProdWidth-RESULT_WIDTH){1'b0}}, Limit});

   assign rsp_data = rsp_ff;

endmodule

// ===== sv/binomial_coefficient_unit_top.sv =====
// binomial coefficient unit: n choose k or n multichoose k, saturating on overflow
// load, setup, then s steps (s = steps run); k above top ends at setup, overflow at the update check
// each step is a multiply, a restoring divide of 64 quotient bits with a done check, then an update
// at 32 bits s is at most 17; one item at a time
// the result beat is shown for one cycle on rsp_strobe; busy drops in that same cycle
// synchronous active-high reset returns the controller to idle with no beat pending
module binomial_coefficient_unit_top #(
   parameter int RESULT_WIDTH = bcu_pkg::ResultWidthDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  bcu_pkg::req_type req_data,
   output logic             rsp_strobe,
   output bcu_pkg::rsp_type rsp_data
);
   import bcu_pkg::*;

   cmd_type    cmd;
   status_type status;

   bcu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .status     (status)
   );

   bcu_dpath #(
      .RESULT_WIDTH (RESULT_WIDTH)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

// ===== verif/tb.sv =====
// self-checking testbench for binomial_coefficient_unit_top: directed table plus random beats
`timescale 1ns / 1ps

module tb;
   import bcu_pkg::*;

   localparam int ResultWidth = ResultWidthDefault;
   localparam longint CycleLimit = 3_000_000;
   localparam logic [InWidth-1:0] AllOnes = '1;

   localparam rsp_type RspZero = '{coefficient: 32'd0, overflow: 1'b0};
   localparam rsp_type RspOne  = '{coefficient: 32'd1, overflow: 1'b0};
   localparam rsp_type RspMax  = '{coefficient: AllOnes, overflow: 1'b0};
   localparam rsp_type RspSat  = '{coefficient: AllOnes, overflow: 1'b1};

   typedef struct packed {
      logic    typed;
      req_type req;
      rsp_type want;
   } directed_row_type;

   typedef struct packed {
      req_type req;
      rsp_type want;
   } pending_coefficient_type;

   // rows with typed set carry their own answer, the rest go through the predictor
   localparam directed_row_type DirectedRows [25] = '{
      '{1'b1, '{OP_CHOOSE,      32'd0,          32'd0},          RspOne},
      '{1'b1, '{OP_CHOOSE,      32'd5,          32'd7},          RspZero},
      '{1'b1, '{OP_CHOOSE,      32'd0,          32'd1},          RspZero},
      '{1'b1, '{OP_CHOOSE,      AllOnes,        32'd0},          RspOne},
      '{1'b1, '{OP_CHOOSE,      AllOnes,        AllOnes},        RspOne},
      '{1'b1, '{OP_CHOOSE,      AllOnes,        32'd1},          RspMax},
      '{1'b1, '{OP_CHOOSE,      AllOnes,        32'd2},          RspSat},
      '{1'b1, '{OP_CHOOSE,      32'd0,          AllOnes},        RspZero},
      '{1'b1, '{OP_CHOOSE,      32'd1,          32'd1},          RspOne},
      '{1'b1, '{OP_MULTICHOOSE, 32'd0,          32'd0},          RspOne},
      '{1'b1, '{OP_MULTICHOOSE, 32'd0,          32'd1},          RspZero},
      '{1'b1, '{OP_MULTICHOOSE, 32'd0,          AllOnes},        RspZero},
      '{1'b1, '{OP_MULTICHOOSE, 32'd1,          AllOnes},        RspOne},
      '{1'b1, '{OP_MULTICHOOSE, AllOnes,        AllOnes},        RspSat},
      '{1'b1, '{OP_MULTICHOOSE, AllOnes,        32'd1},          RspMax},
      '{1'b1, '{OP_MULTICHOOSE, AllOnes,        32'd0},          RspOne},
      '{1'b0, '{OP_MULTICHOOSE, 32'd2,          AllOnes},        RspZero},
      '{1'b0, '{OP_CHOOSE,      32'd34,         32'd17},         RspZero},
      '{1'b0, '{OP_CHOOSE,      32'd35,         32'd17},         RspZero},
      '{1'b0, '{OP_CHOOSE,      32'd35,         32'd18},         RspZero},
      '{1'b0, '{OP_CHOOSE,      32'd92682,      32'd2},          RspZero},
      '{1'b0, '{OP_CHOOSE,      32'd92683,      32'd2},          RspZero},
      '{1'b0, '{OP_MULTICHOOSE, 32'd17,         32'd17},         RspZero},
      '{1'b0, '{OP_MULTICHOOSE, 32'd18,         32'd17},         RspZero},
      '{1'b0, '{OP_CHOOSE,      32'h8000_0000,  32'h7FFF_FFFF},  RspZero}
   };

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   pending_coefficient_type expected_coefficients [$];
   pending_coefficient_type oldest;
   int                      coefficient_errors = 0;
   longint                  cycle_count = 0;
   int                      sender_idle_pct [4] = '{0, 76, 0, 18};

   binomial_coefficient_unit_top #(
      .RESULT_WIDTH(ResultWidth)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // exact multiply-then-divide, stops as soon as the running value leaves the result range
   function automatic rsp_type predict_coefficient(input req_type r);
      logic [TopWidth-1:0] top;
      longint unsigned     top_n;
      longint unsigned     pick;
      longint unsigned     steps;
      longint unsigned     c;
      longint unsigned     ceiling;
      longint unsigned     i;
      rsp_type             res;
      if (r.operation == OP_MULTICHOOSE)
         top = {1'b0, r.n_value} + {1'b0, r.k_value} - 33'd1;
      else
         top = {1'b0, r.n_value};
      top_n   = 64'(top);
      pick    = 64'(r.k_value);
      ceiling = (64'd1 << ResultWidth) - 64'd1;
      res     = RspZero;
      if (pick > top_n)
         return res;
      steps = top_n - pick;
      if (pick < steps)
         steps = pick;
      c = 64'd1;
      for (i = 64'd0; i < steps; i++) begin
         c = (c * (top_n - i)) / (i + 64'd1);
         if (c > ceiling) begin
            res.coefficient = ceiling[InWidth-1:0];
            res.overflow    = 1'b1;
            return res;
         end
      end
      res.coefficient = c[InWidth-1:0];
      return res;
   endfunction

   // mix of exact-fit, boundary, k above n, wrap and fully random operands
   function automatic req_type random_request();
      req_type r;
      r.operation = $urandom_range(1) ? OP_MULTICHOOSE : OP_CHOOSE;
      r.n_value   = $urandom;
      r.k_value   = $urandom;
      case ($urandom_range(9))
         1: begin
            r.operation = OP_CHOOSE;
            r.n_value   = $urandom_range(0, 70);
            r.k_value   = $urandom_range(0, r.n_value + 2);
         end
         2: begin
            r.operation = OP_MULTICHOOSE;
            r.n_value   = $urandom_range(0, 40);
            r.k_value   = $urandom_range(0, 40);
         end
         3: r.k_value = $urandom_range(0, 4);
         4: begin
            r.operation = OP_CHOOSE;
            r.k_value   = r.n_value - $urandom_range(0, 4);
         end
         5: begin
            r.n_value = $urandom_range(0, 200000);
            r.k_value = $urandom_range(0, 6);
         end
         6: begin
            r.operation = OP_CHOOSE;
            r.n_value   = $urandom_range(0, 1000);
            r.k_value   = r.n_value + $urandom_range(1, 5);
         end
         7: begin
            r.operation = OP_MULTICHOOSE;
            r.k_value   = $urandom_range(0, 3);
         end
         8: begin
            r.operation = OP_MULTICHOOSE;
            r.n_value   = $urandom_range(0, 3);
         end
         9: begin
            r.operation = OP_CHOOSE;
            r.n_value   = $urandom_range(28, 40);
            r.k_value   = r.n_value / 2 + $urandom_range(0, 4) - 2;
         end
         default: ;
      endcase
      return r;
   endfunction

   // start stays high until the beat is taken; the expectation is queued at that edge
   task automatic present_request(input req_type r, input rsp_type want);
      req_data <= r;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      expected_coefficients.push_back('{req: r, want: want});
   endtask

   // long gaps let the next start land anywhere in the block's busy window
   task automatic hold_off(input int pct);
      int gap;
      if ($urandom_range(99) < pct) begin
         gap   = $urandom_range(1) ? $urandom_range(1, 8) : $urandom_range(9, 1500);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (DirectedRows[row])
         present_request(DirectedRows[row].req,
                         DirectedRows[row].typed ? DirectedRows[row].want
                                                 : predict_coefficient(DirectedRows[row].req));

      foreach (sender_idle_pct[phase]) begin
         for (int j = 0; j < 125; j++) begin
            req_type r;
            hold_off(sender_idle_pct[phase]);
            r = random_request();
            present_request(r, predict_coefficient(r));
         end
      end
      start <= 1'b0;

      while (expected_coefficients.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (coefficient_errors == 0)
         $display("binomial_coefficient_unit_top: match");
      else
         $display("binomial_coefficient_unit_top: mismatch");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_coefficients.size() == 0) begin
            if (coefficient_errors < 10)
               $display("result beat with nothing pending: coefficient %0d overflow %0b",
                        rsp_data.coefficient, rsp_data.overflow);
            coefficient_errors++;
         end else begin
            oldest = expected_coefficients.pop_front();
            if (rsp_data.coefficient !== oldest.want.coefficient ||
                rsp_data.overflow !== oldest.want.overflow) begin
               if (coefficient_errors < 10)
                  $display("op %0b n %0d k %0d: expected %0d/%0b, got %0d/%0b",
                           oldest.req.operation, oldest.req.n_value, oldest.req.k_value,
                           oldest.want.coefficient, oldest.want.overflow,
                           rsp_data.coefficient, rsp_data.overflow);
               coefficient_errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("binomial_coefficient_unit_top: mismatch");
         $finish;
      end
   end

endmodule
